/* src/ip_blacklist_hash_filter_macros.svh */
// Assertion macros for the blacklist hash filter.
`ifndef IP_BLACKLIST_HASH_FILTER_MACROS_SVH
`define IP_BLACKLIST_HASH_FILTER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define IPBL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ipbl assertion failed");
// Next-cycle implication.
`define IPBL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ipbl assertion failed");
`else
`define IPBL_ASSERT_IMPL(label, clk, rst, ante, cons)
`define IPBL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* src/ipbl_pkg.sv */
// Shared types and constants of the blacklist hash filter.
`timescale 1ns / 1ps
package ipbl_pkg;

   localparam int BUCKET_COUNT_DEF = 1021;
   localparam int BUCKET_DEPTH_DEF = 8;
   localparam int MIN_PREFIX_DEF   = 20;

   localparam int ADDR_W = 32;
   localparam int PLEN_W = 6;

   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_INSERT = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_SHORT = 2'd2;

   typedef struct packed {
      logic              func;
      logic [ADDR_W-1:0] address;
      logic              has_prefix;
      logic [PLEN_W-1:0] prefix_len;
   } ipbl_req_type;

   typedef struct packed {
      logic       accepted;
      logic [1:0] status;
   } ipbl_rsp_type;

endpackage

/* src/ipbl_if.sv */
// Valid/ready stream interfaces for requests and responses.
`timescale 1ns / 1ps
interface ipbl_req_if;
   import ipbl_pkg::*;
   logic         valid;
   logic         ready;
   ipbl_req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ipbl_rsp_if;
   import ipbl_pkg::*;
   logic         valid;
   logic         ready;
   ipbl_rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* src/ipbl_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ipbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* src/ipbl_mod.sv */
// Address modulo bucket count by reciprocal multiplication, in registered steps.
`timescale 1ns / 1ps
module ipbl_mod #(
   parameter int BUCKET_COUNT = ipbl_pkg::BUCKET_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ipbl_pkg::ADDR_W-1:0]     dividend,
   output logic                            done,
   output logic [$clog2(BUCKET_COUNT)-1:0] remainder
);
   import ipbl_pkg::*;

   localparam int BW     = $clog2(BUCKET_COUNT);
   localparam int BW1    = BW + 1;
   localparam int PROD_W = 2 * ADDR_W;
   // floor(a * RECIP / 2^SHIFT) is the exact quotient or one below it
   localparam int SHIFT  = ADDR_W - 1 + BW;
   localparam int QUOT_W = PROD_W - SHIFT;
   localparam logic [ADDR_W-1:0] RECIP     = ADDR_W'((64'd1 << SHIFT) / BUCKET_COUNT);
   localparam logic [ADDR_W-1:0] DIVISOR_W = ADDR_W'(BUCKET_COUNT);
   localparam logic [BW:0]       DIVISOR   = BW1'(BUCKET_COUNT);

   logic [ADDR_W-1:0] num_ff, num_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [BW:0]       part_ff, part_in;
   logic [BW-1:0]     rem_ff, rem_in;
   logic [QUOT_W-1:0] quot;
   logic [ADDR_W-1:0] quot_mul;
   logic              stage1_ff;
   logic              stage2_ff;
   logic              stage3_ff;
   logic              done_ff;

   assign num_in   = start ? dividend : num_ff;
   assign prod_in  = PROD_W'(num_ff) * PROD_W'(RECIP);
   assign quot     = prod_ff[PROD_W-1:SHIFT];
   assign quot_mul = ADDR_W'(quot) * DIVISOR_W;
   // partial remainder is below twice the divisor
   assign part_in  = BW1'(num_ff - quot_mul);
   assign rem_in   = (part_ff >= DIVISOR) ? BW'(part_ff - DIVISOR) : part_ff[BW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff <= 1'b0;
         stage2_ff <= 1'b0;
         stage3_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         stage1_ff <= start;
         stage2_ff <= stage1_ff;
         stage3_ff <= stage2_ff;
         done_ff   <= stage3_ff;
      end
      num_ff  <= num_in;
      prod_ff <= prod_in;
      part_ff <= part_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule

/* src/ip_blacklist_hash_filter.sv */
// Hashed IPv4 blacklist: bucket fill counts and entries in two RAMs, one sequencer.
// A lookup reads the fill count of its bucket and scans the entries in it; a plain insert
// writes one entry and a prefix insert one entry per host; a refused or empty prefix is
// answered without the modulo unit. One request at a time: the next transfer can come in the
// cycle that the response turns valid at the earliest; the modulo unit and the scan set the pace.
// Synchronous reset, then a clearing pass over every bucket of the fill RAM.
`timescale 1ns / 1ps
`include "ip_blacklist_hash_filter_macros.svh"
module ip_blacklist_hash_filter #(
   parameter int BUCKET_COUNT = ipbl_pkg::BUCKET_COUNT_DEF,
   parameter int BUCKET_DEPTH = ipbl_pkg::BUCKET_DEPTH_DEF,
   parameter int MIN_PREFIX   = ipbl_pkg::MIN_PREFIX_DEF
) (
   input logic        clock,
   input logic        reset,
   ipbl_req_if.sink   req_chan,
   ipbl_rsp_if.source rsp_chan
);
   import ipbl_pkg::*;

   localparam int BUCKET_W  = $clog2(BUCKET_COUNT);
   localparam int SLOT_W    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
   localparam int FILL_W    = $clog2(BUCKET_DEPTH + 1);
   localparam int HOST_W    = ADDR_W - MIN_PREFIX;
   localparam int ENT_DEPTH = BUCKET_COUNT * (2 ** SLOT_W);
   localparam int ENT_AW    = BUCKET_W + SLOT_W;

   localparam logic [2:0] S_CLEAR    = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_MOD      = 3'd2;
   localparam logic [2:0] S_FILL     = 3'd3;
   localparam logic [2:0] S_DECIDE   = 3'd4;
   localparam logic [2:0] S_SCAN     = 3'd5;
   localparam logic [2:0] S_SCAN_END = 3'd6;
   localparam logic [2:0] S_DONE     = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [BUCKET_W-1:0] clr_ff, clr_in;
   logic                func_ff, func_in;
   logic [ADDR_W-1:0]   target_ff, target_in;
   logic [HOST_W-1:0]   hosts_ff, hosts_in;
   logic [BUCKET_W-1:0] bucket_ff, bucket_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                cmp_pend_ff, cmp_pend_in;
   logic                hit_ff, hit_in;
   logic                full_ff, full_in;
   logic                res_acc_ff, res_acc_in;
   logic [1:0]          res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ipbl_rsp_type        rsp_data_ff, rsp_data_in;

   logic [BUCKET_W-1:0] bucket_next;
   logic [PLEN_W-1:0]   host_bits;
   logic [ADDR_W-1:0]   span_m1;
   logic [ADDR_W-1:0]   pfx_target;
   logic [HOST_W-1:0]   pfx_hosts;
   logic [FILL_W-1:0]   fill_last;
   logic                req_xfer;
   logic                match;

   logic                mod_start;
   logic [ADDR_W-1:0]   mod_dividend;
   logic                mod_done;
   logic [BUCKET_W-1:0] mod_rem;

   logic                fill_wr_en;
   logic [BUCKET_W-1:0] fill_wr_addr;
   logic [FILL_W-1:0]   fill_wr_data;
   logic [BUCKET_W-1:0] fill_rd_addr;
   logic [FILL_W-1:0]   fill_rd_data;

   logic                ent_wr_en;
   logic [ENT_AW-1:0]   ent_wr_addr;
   logic [ENT_AW-1:0]   ent_rd_addr;
   logic [ADDR_W-1:0]   ent_rd_data;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // first host address of the prefix and host count
   assign host_bits  = PLEN_W'(ADDR_W) - req_chan.data.prefix_len;
   assign span_m1    = (ADDR_W'(1) << host_bits) - ADDR_W'(1);
   assign pfx_target = (req_chan.data.address & ~span_m1) + ADDR_W'(1);
   assign pfx_hosts  = HOST_W'(span_m1) - HOST_W'(1);

   assign bucket_next = (bucket_ff == BUCKET_W'(BUCKET_COUNT - 1)) ? '0
                                                                    : BUCKET_W'(bucket_ff + 1'b1);
   assign fill_last    = FILL_W'(fill_ff - 1'b1);
   assign match        = (ent_rd_data == target_ff);
   // consecutive hosts hit consecutive buckets, so the read runs one bucket ahead
   assign fill_rd_addr = (state_ff == S_DECIDE) ? bucket_next : bucket_ff;
   assign ent_rd_addr  = {bucket_ff, slot_ff};
   assign ent_wr_addr  = {bucket_ff, fill_rd_data[SLOT_W-1:0]};

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      func_in       = func_ff;
      target_in     = target_ff;
      hosts_in      = hosts_ff;
      bucket_in     = bucket_ff;
      fill_in       = fill_ff;
      slot_in       = slot_ff;
      cmp_pend_in   = cmp_pend_ff;
      hit_in        = hit_ff;
      full_in       = full_ff;
      res_acc_in    = res_acc_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in   = rsp_data_ff;
      mod_start     = 1'b0;
      mod_dividend  = req_chan.data.address;
      fill_wr_en    = 1'b0;
      fill_wr_addr  = bucket_ff;
      fill_wr_data  = FILL_W'(fill_rd_data + 1'b1);
      ent_wr_en     = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            fill_wr_en   = 1'b1;
            fill_wr_addr = clr_ff;
            fill_wr_data = '0;
            if (clr_ff == BUCKET_W'(BUCKET_COUNT - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = BUCKET_W'(clr_ff + 1'b1);
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               func_in    = req_chan.data.func;
               target_in  = req_chan.data.address;
               hosts_in   = HOST_W'(1);
               hit_in     = 1'b0;
               full_in    = 1'b0;
               res_acc_in = 1'b0;
               priority if (req_chan.data.func == FUNC_LOOKUP || !req_chan.data.has_prefix) begin
                  mod_start = 1'b1;
                  state_in  = S_MOD;
               end else if (req_chan.data.prefix_len < PLEN_W'(MIN_PREFIX)) begin
                  res_status_in = ST_SHORT;
                  state_in      = S_DONE;
               end else if (req_chan.data.prefix_len > PLEN_W'(ADDR_W - 2)) begin
                  // /31, /32 and beyond hold no usable host
                  res_status_in = ST_OK;
                  state_in      = S_DONE;
               end else begin
                  target_in    = pfx_target;
                  hosts_in     = pfx_hosts;
                  mod_dividend = pfx_target;
                  mod_start    = 1'b1;
                  state_in     = S_MOD;
               end
            end
         end
         S_MOD: begin
            if (mod_done) begin
               bucket_in = mod_rem;
               state_in  = S_FILL;
            end
         end
         S_FILL: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (func_ff == FUNC_LOOKUP) begin
               if (fill_rd_data == '0) begin
                  res_acc_in    = 1'b1;
                  res_status_in = ST_OK;
                  state_in      = S_DONE;
               end else begin
                  fill_in     = fill_rd_data;
                  slot_in     = '0;
                  cmp_pend_in = 1'b0;
                  state_in    = S_SCAN;
               end
            end else begin
               if (fill_rd_data < FILL_W'(BUCKET_DEPTH)) begin
                  fill_wr_en = 1'b1;
                  ent_wr_en  = 1'b1;
               end else begin
                  full_in = 1'b1;
               end
               if (hosts_ff == HOST_W'(1)) begin
                  res_status_in = (full_in) ? ST_FULL : ST_OK;
                  state_in      = S_DONE;
               end else begin
                  hosts_in  = HOST_W'(hosts_ff - 1'b1);
                  target_in = target_ff + ADDR_W'(1);
                  bucket_in = bucket_next;
               end
            end
         end
         S_SCAN: begin
            cmp_pend_in = 1'b1;
            hit_in      = hit_ff || (cmp_pend_ff && match);
            if (slot_ff == fill_last[SLOT_W-1:0]) begin
               state_in = S_SCAN_END;
            end else begin
               slot_in = SLOT_W'(slot_ff + 1'b1);
            end
         end
         S_SCAN_END: begin
            res_acc_in    = !(hit_ff || match);
            res_status_in = ST_OK;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.accepted = res_acc_ff;
               rsp_data_in.status   = res_status_ff;
               state_in             = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      target_ff     <= target_in;
      hosts_ff      <= hosts_in;
      bucket_ff     <= bucket_in;
      fill_ff       <= fill_in;
      slot_ff       <= slot_in;
      cmp_pend_ff   <= cmp_pend_in;
      hit_ff        <= hit_in;
      full_ff       <= full_in;
      res_acc_ff    <= res_acc_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   ipbl_mod #(
      .BUCKET_COUNT(BUCKET_COUNT)
   ) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (mod_dividend),
      .done     (mod_done),
      .remainder(mod_rem)
   );

   ipbl_ram #(
      .WIDTH(FILL_W),
      .DEPTH(BUCKET_COUNT)
   ) u_fill_ram (
      .clock  (clock),
      .wr_en  (fill_wr_en),
      .wr_addr(fill_wr_addr),
      .wr_data(fill_wr_data),
      .rd_addr(fill_rd_addr),
      .rd_data(fill_rd_data)
   );

   ipbl_ram #(
      .WIDTH(ADDR_W),
      .DEPTH(ENT_DEPTH)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (ent_wr_en),
      .wr_addr(ent_wr_addr),
      .wr_data(target_ff),
      .rd_addr(ent_rd_addr),
      .rd_data(ent_rd_data)
   );

   `IPBL_ASSERT_IMPL(a_mod_done_in_mod, clock, reset, mod_done, state_ff == S_MOD)
   `IPBL_ASSERT_IMPL(a_fill_bounded, clock, reset, fill_wr_en, fill_wr_data <= FILL_W'(BUCKET_DEPTH))
   `IPBL_ASSERT_IMPL(a_bucket_range, clock, reset, state_ff == S_DECIDE, bucket_ff <= BUCKET_W'(BUCKET_COUNT - 1))
   `IPBL_ASSERT_NEXT(a_lookup_no_write, clock, reset, state_ff == S_SCAN, !ent_wr_en && !fill_wr_en)
endmodule
